### sv/hmap_pkg.sv
// Shared types and constants for the heading min-accel planner.
package hmap_pkg;

  // Time fraction bits (Q16.16 seconds)
  localparam int unsigned TIME_FRAC = 16;

  // Multiplier operand and product widths
  localparam int unsigned MUL_AW = 61;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // Divider widths: numerator, divisor, quotient
  localparam int unsigned DIV_NW = 52;
  localparam int unsigned DIV_DW = 49;
  localparam int unsigned DIV_QW = DIV_NW + TIME_FRAC;

  // Iteration counts
  localparam int unsigned MUL_STEPS  = MUL_BW;
  localparam int unsigned DIV_STEPS  = DIV_QW;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  // Request kinds
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_NUDGE = 2'd2;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_TIME,
    SH_TIME_HALF
  } shift_e;

  typedef enum logic [2:0] {
    CAP_TERM,
    CAP_TV,
    CAP_Q1,
    CAP_VEL,
    CAP_SW
  } cap_e;

  typedef struct packed {
    alu_op_e     op;
    shift_e      sh;
    cap_e        cap;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        neg;
    logic [63:0] mag;
  } alu_rsp_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] target_heading;
    logic [31:0]        move_duration;
    logic [31:0]        tick_delta;
    logic signed [31:0] nudge_delta;
  } req_t;

  typedef struct packed {
    logic signed [31:0] heading;
    logic               plan_running;
  } rsp_t;

  // Saturation limit for each cap code
  function automatic logic [63:0] cap_value(cap_e sel);
    logic [63:0] v;
    case (sel)
      CAP_TERM: v = 64'h1000_0000_0000_0000;
      CAP_TV:   v = 64'h0000_4000_0000_0000;
      CAP_Q1:   v = 64'h2000_0000_0000_0000;
      CAP_VEL:  v = 64'h0000_7FFF_FFFF_FFFF;
      CAP_SW:   v = 64'h0000_0100_0000_0000;
      default:  v = 64'h0000_7FFF_FFFF_FFFF;
    endcase
    return v;
  endfunction

endpackage

### sv/hmap_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
module hmap_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hmap_pkg::alu_req_t req_i,
  output hmap_pkg::alu_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_SQRT,
    A_FIN
  } alu_state_e;

  localparam int unsigned PW = hmap_pkg::MUL_PW;
  localparam int unsigned AW = hmap_pkg::MUL_AW;
  localparam int unsigned BW = hmap_pkg::MUL_BW;
  localparam int unsigned NW = hmap_pkg::DIV_NW;
  localparam int unsigned DW = hmap_pkg::DIV_DW;
  localparam int unsigned QW = hmap_pkg::DIV_QW;
  localparam int unsigned CW = hmap_pkg::CNT_W;

  alu_state_e          st_q;
  logic [CW-1:0]       cnt_q;
  hmap_pkg::alu_op_e   op_q;
  hmap_pkg::shift_e    sh_q;
  hmap_pkg::cap_e      cap_q;
  logic                neg_q;
  logic [AW-1:0]       a_q;
  logic [BW-1:0]       b_q;
  logic [PW-1:0]       prod_q;
  logic [NW-1:0]       num_q;
  logic [DW-1:0]       den_q;
  logic [DW-1:0]       rem_q;
  logic [QW-1:0]       quo_q;
  logic [63:0]         sx_q;
  logic [63:0]         sres_q;
  logic [63:0]         sbit_q;
  hmap_pkg::alu_rsp_t  rsp_q;

  logic [63:0]   a_mag;
  logic [63:0]   b_mag;
  logic [PW-1:0] mul_step;
  logic [DW:0]   div_r2;
  logic          div_ge;
  logic [DW:0]   div_sub;
  logic [63:0]   sq_try;
  logic          sq_ge;
  logic [PW-1:0] fin_val;
  logic [63:0]   cap_v;
  logic [63:0]   fin_mag;
  logic          last;

  // Operand magnitudes
  assign a_mag = req_i.a[63] ? (~req_i.a + 64'd1) : req_i.a;
  assign b_mag = req_i.b[63] ? (~req_i.b + 64'd1) : req_i.b;

  // One shift-add step, MSB of the multiplier first
  assign mul_step = {prod_q[PW-2:0], 1'b0} + (b_q[BW-1] ? {{BW{1'b0}}, a_q} : '0);

  // One restoring-divide step
  assign div_r2  = {rem_q, num_q[NW-1]};
  assign div_ge  = div_r2 >= {1'b0, den_q};
  assign div_sub = div_r2 - {1'b0, den_q};

  // One square-root digit
  assign sq_try = sres_q + sbit_q;
  assign sq_ge  = sx_q >= sq_try;

  // Step counter end
  always_comb begin
    case (op_q)
      hmap_pkg::ALU_MUL:  last = cnt_q == CW'(hmap_pkg::MUL_STEPS - 1);
      hmap_pkg::ALU_DIV:  last = cnt_q == CW'(hmap_pkg::DIV_STEPS - 1);
      hmap_pkg::ALU_SQRT: last = cnt_q == CW'(hmap_pkg::SQRT_STEPS - 1);
      default:            last = 1'b1;
    endcase
  end

  // Final scaling and saturation
  always_comb begin
    case (op_q)
      hmap_pkg::ALU_MUL: begin
        case (sh_q)
          hmap_pkg::SH_TIME:      fin_val = prod_q >> hmap_pkg::TIME_FRAC;
          hmap_pkg::SH_TIME_HALF: fin_val = prod_q >> (hmap_pkg::TIME_FRAC + 1);
          default:                fin_val = prod_q;
        endcase
      end
      hmap_pkg::ALU_DIV:  fin_val = PW'(quo_q);
      hmap_pkg::ALU_SQRT: fin_val = PW'(sres_q);
      default:            fin_val = '0;
    endcase
    cap_v   = hmap_pkg::cap_value(cap_q);
    fin_mag = (fin_val > PW'(cap_v)) ? cap_v : fin_val[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      cnt_q  <= '0;
      op_q   <= hmap_pkg::ALU_MUL;
      sh_q   <= hmap_pkg::SH_NONE;
      cap_q  <= hmap_pkg::CAP_TERM;
      neg_q  <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      prod_q <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      sx_q   <= '0;
      sres_q <= '0;
      sbit_q <= '0;
      rsp_q  <= '0;
    end else begin
      rsp_q.done <= (st_q == A_FIN);
      case (st_q)
        A_IDLE: begin
          if (start_i) begin
            op_q  <= req_i.op;
            sh_q  <= req_i.sh;
            cap_q <= req_i.cap;
            cnt_q <= '0;
            case (req_i.op)
              hmap_pkg::ALU_MUL: begin
                a_q    <= a_mag[AW-1:0];
                b_q    <= req_i.b[BW-1:0];
                prod_q <= '0;
                neg_q  <= req_i.a[63];
                st_q   <= A_MUL;
              end
              hmap_pkg::ALU_DIV: begin
                num_q <= a_mag[NW-1:0];
                den_q <= b_mag[DW-1:0];
                rem_q <= '0;
                quo_q <= '0;
                neg_q <= req_i.a[63] ^ req_i.b[63];
                st_q  <= A_DIV;
              end
              hmap_pkg::ALU_SQRT: begin
                sx_q   <= req_i.a;
                sres_q <= '0;
                sbit_q <= 64'h4000_0000_0000_0000;
                neg_q  <= 1'b0;
                st_q   <= A_SQRT;
              end
              default: st_q <= A_IDLE;
            endcase
          end
        end
        A_MUL: begin
          prod_q <= mul_step;
          b_q    <= {b_q[BW-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (last) st_q <= A_FIN;
        end
        A_DIV: begin
          num_q <= {num_q[NW-2:0], 1'b0};
          if (div_ge) begin
            rem_q <= div_sub[DW-1:0];
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= div_r2[DW-1:0];
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (last) st_q <= A_FIN;
        end
        A_SQRT: begin
          if (sq_ge) begin
            sx_q   <= sx_q - sq_try;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          cnt_q  <= cnt_q + 1'b1;
          if (last) st_q <= A_FIN;
        end
        A_FIN: begin
          rsp_q.neg  <= neg_q;
          rsp_q.mag  <= fin_mag;
          st_q       <= A_IDLE;
        end
        default: st_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule

### sv/heading_min_accel_planner_unit.sv
// Heading planner top level: request sequencer around the shared arithmetic unit.
// Smooths a Q8.24 heading toward a target with an accelerate/decelerate profile.
// One request is worked at a time; in_stall_o is high until its result is
// loaded into the output register. All multiplies, divides and square roots
// run through one iterative unit. A nudge, a zero-duration set, an idle tick
// or an unused code uses no unit operation; a tick inside a plan issues three
// multiplies before the switch point and six after it; a set with a plan
// issues up to four divides (root search plus root pick or fallback plan).
module heading_min_accel_planner_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hmap_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hmap_pkg::rsp_t out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SET_CHK,
    ST_PV_A,
    ST_PV_B,
    ST_PV_END,
    ST_SETUP,
    ST_SV_P,
    ST_SV_NORM,
    ST_SV_SQX,
    ST_SV_SQY,
    ST_SV_SQRT,
    ST_SV_C,
    ST_SV_CA,
    ST_SV_PICK,
    ST_FR_Q1,
    ST_FR_A,
    ST_TK_CHK,
    ST_PP_VT,
    ST_PP_AT,
    ST_PP_HALF,
    ST_PP_V1T,
    ST_PP_ADT,
    ST_PP_HALF2,
    ST_PP_END,
    ST_NUDGE,
    ST_FINISH
  } seq_state_e;

  seq_state_e         state_q;
  logic               issued_q;
  hmap_pkg::req_t     req_q;
  logic signed [31:0] heading_q;
  logic signed [31:0] start_q;
  logic signed [31:0] target_q;
  logic signed [47:0] vel0_q;
  logic signed [47:0] accel_q;
  logic [31:0]        switch_q;
  logic [31:0]        dur_q;
  logic [31:0]        elapsed_q;
  logic signed [47:0] v0n_q;
  logic signed [32:0] dist_q;
  logic [46:0]        x_q;
  logic [46:0]        y_q;
  logic [4:0]         k_q;
  logic [63:0]        sq_q;
  logic [48:0]        s_q;
  logic               cand_q;
  logic               found_q;
  logic signed [47:0] best_q;
  logic [46:0]        best_mag_q;
  logic [31:0]        bt_q;
  logic [31:0]        c_q;
  logic signed [33:0] diff_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] tmp_q;
  logic signed [47:0] v1_q;
  logic               past_q;
  logic               out_valid_q;
  hmap_pkg::rsp_t     out_data_q;

  hmap_pkg::alu_req_t alu_req;
  hmap_pkg::alu_rsp_t alu_rsp;
  logic               alu_call;
  logic               alu_start;
  logic               alu_done;
  logic signed [63:0] alu_val;

  logic [31:0]        t_a;
  logic [31:0]        t_d;
  logic               el_le_sw;
  logic [32:0]        el_sum;
  logic [31:0]        el_sat;
  logic signed [63:0] e_val;
  logic [63:0]        e_mag;
  logic [32:0]        d_mag;
  logic signed [63:0] cand_n;
  logic               c_skip;
  logic signed [41:0] diff_w;

  function automatic logic [63:0] ext48(logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  function automatic logic [63:0] ext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] ext33(logic [32:0] v);
    return {{31{v[32]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] clamp_vel(logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'sh0000_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -64'sh0000_7FFF_FFFF_FFFF) r = 48'sh8000_0000_0001;
    else r = v[47:0];
    return r;
  endfunction

  // Signed view of the unit's result
  assign alu_done = alu_rsp.done;
  assign alu_val  = $signed(alu_rsp.neg ? (~alu_rsp.mag + 64'd1) : alu_rsp.mag);

  // Profile times
  assign el_le_sw = elapsed_q <= switch_q;
  assign t_a      = past_q ? switch_q : elapsed_q;
  assign t_d      = elapsed_q - switch_q;
  assign el_sum   = {1'b0, elapsed_q} + {1'b0, req_q.tick_delta};
  assign el_sat   = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

  // Discriminant and candidate terms
  assign e_val  = alu_val - $signed(ext33(dist_q));
  assign e_mag  = e_val[63] ? (~e_val + 64'd1) : e_val;
  assign d_mag  = dist_q[32] ? (~dist_q + 33'd1) : dist_q;
  assign cand_n = $signed(ext33(dist_q) << 1)
                  + (cand_q ? $signed({15'b0, s_q}) : -$signed({15'b0, s_q}));
  assign c_skip = ((alu_rsp.mag != 64'd0) && alu_rsp.neg)
                  || (alu_rsp.mag > {32'b0, dur_q});
  assign diff_w = $signed({10'b0, dur_q}) - $signed({alu_rsp.mag[40:0], 1'b0});

  // Request to the shared unit for each calling state
  always_comb begin
    alu_req.op  = hmap_pkg::ALU_MUL;
    alu_req.sh  = hmap_pkg::SH_TIME;
    alu_req.cap = hmap_pkg::CAP_TERM;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_call    = 1'b1;
    case (state_q)
      ST_PV_A: begin
        alu_req.a = ext48(accel_q);
        alu_req.b = {32'b0, el_le_sw ? elapsed_q : switch_q};
      end
      ST_PV_B: begin
        alu_req.a = ext48(accel_q);
        alu_req.b = {32'b0, t_d};
      end
      ST_SV_P: begin
        alu_req.cap = hmap_pkg::CAP_TV;
        alu_req.a   = ext48(v0n_q);
        alu_req.b   = {32'b0, dur_q};
      end
      ST_SV_SQX: begin
        alu_req.sh = hmap_pkg::SH_NONE;
        alu_req.a  = {34'b0, x_q[29:0]};
        alu_req.b  = {34'b0, x_q[29:0]};
      end
      ST_SV_SQY: begin
        alu_req.sh = hmap_pkg::SH_NONE;
        alu_req.a  = {34'b0, y_q[29:0]};
        alu_req.b  = {34'b0, y_q[29:0]};
      end
      ST_SV_SQRT: begin
        alu_req.op = hmap_pkg::ALU_SQRT;
        alu_req.a  = sq_q;
      end
      ST_SV_C: begin
        alu_req.op  = hmap_pkg::ALU_DIV;
        alu_req.cap = hmap_pkg::CAP_SW;
        alu_req.a   = cand_n;
        alu_req.b   = ext48(v0n_q) << 1;
      end
      ST_SV_CA: begin
        alu_req.op  = hmap_pkg::ALU_DIV;
        alu_req.cap = hmap_pkg::CAP_VEL;
        alu_req.a   = ext48(v0n_q);
        alu_req.b   = {{30{diff_q[33]}}, diff_q};
      end
      ST_FR_Q1: begin
        alu_req.op  = hmap_pkg::ALU_DIV;
        alu_req.cap = hmap_pkg::CAP_Q1;
        alu_req.a   = ext33(dist_q) << 2;
        alu_req.b   = {32'b0, dur_q};
      end
      ST_FR_A: begin
        alu_req.op  = hmap_pkg::ALU_DIV;
        alu_req.cap = hmap_pkg::CAP_VEL;
        alu_req.a   = tmp_q;
        alu_req.b   = {32'b0, dur_q};
      end
      ST_PP_VT: begin
        alu_req.a = ext48(vel0_q);
        alu_req.b = {32'b0, t_a};
      end
      ST_PP_AT: begin
        alu_req.a = ext48(accel_q);
        alu_req.b = {32'b0, t_a};
      end
      ST_PP_HALF: begin
        alu_req.sh = hmap_pkg::SH_TIME_HALF;
        alu_req.a  = tmp_q;
        alu_req.b  = {32'b0, t_a};
      end
      ST_PP_V1T: begin
        alu_req.a = ext48(v1_q);
        alu_req.b = {32'b0, t_d};
      end
      ST_PP_ADT: begin
        alu_req.a = ext48(accel_q);
        alu_req.b = {32'b0, t_d};
      end
      ST_PP_HALF2: begin
        alu_req.sh = hmap_pkg::SH_TIME_HALF;
        alu_req.a  = tmp_q;
        alu_req.b  = {32'b0, t_d};
      end
      default: alu_call = 1'b0;
    endcase
  end

  assign alu_start = alu_call && !issued_q;

  hmap_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .req_i   (alu_req),
    .rsp_o   (alu_rsp)
  );

  // Sequencer, planner state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      req_q       <= '0;
      heading_q   <= '0;
      start_q     <= '0;
      target_q    <= '0;
      vel0_q      <= '0;
      accel_q     <= '0;
      switch_q    <= '0;
      dur_q       <= '0;
      elapsed_q   <= '0;
      v0n_q       <= '0;
      dist_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      k_q         <= '0;
      sq_q        <= '0;
      s_q         <= '0;
      cand_q      <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_mag_q  <= '0;
      bt_q        <= '0;
      c_q         <= '0;
      diff_q      <= '0;
      acc_q       <= '0;
      tmp_q       <= '0;
      v1_q        <= '0;
      past_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) out_valid_q <= 1'b0;
      if (alu_start) issued_q <= 1'b1;
      if (alu_done) issued_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            case (in_data_i.req_type)
              hmap_pkg::REQ_SET:   state_q <= ST_SET_CHK;
              hmap_pkg::REQ_TICK:  state_q <= ST_TK_CHK;
              hmap_pkg::REQ_NUDGE: state_q <= ST_NUDGE;
              default:             state_q <= ST_FINISH;
            endcase
          end
        end

        // Set request: snap, or carry the current velocity into a new plan
        ST_SET_CHK: begin
          if (req_q.move_duration == 32'd0) begin
            heading_q <= req_q.target_heading;
            dur_q     <= '0;
            state_q   <= ST_FINISH;
          end else if (dur_q == 32'd0) begin
            v0n_q   <= '0;
            state_q <= ST_SETUP;
          end else begin
            state_q <= ST_PV_A;
          end
        end
        ST_PV_A: begin
          if (alu_done) begin
            acc_q   <= $signed(ext48(vel0_q)) + alu_val;
            state_q <= el_le_sw ? ST_PV_END : ST_PV_B;
          end
        end
        ST_PV_B: begin
          if (alu_done) begin
            acc_q   <= acc_q - alu_val;
            state_q <= ST_PV_END;
          end
        end
        ST_PV_END: begin
          v0n_q   <= clamp_vel(acc_q);
          state_q <= ST_SETUP;
        end
        ST_SETUP: begin
          start_q   <= heading_q;
          target_q  <= req_q.target_heading;
          vel0_q    <= v0n_q;
          elapsed_q <= '0;
          dur_q     <= req_q.move_duration;
          dist_q    <= {req_q.target_heading[31], req_q.target_heading}
                       - {heading_q[31], heading_q};
          state_q   <= (v0n_q == 48'sd0) ? ST_FR_Q1 : ST_SV_P;
        end

        // Closed-form root search
        ST_SV_P: begin
          if (alu_done) begin
            x_q     <= e_mag[46:0];
            y_q     <= {14'b0, d_mag};
            k_q     <= '0;
            state_q <= ST_SV_NORM;
          end
        end
        ST_SV_NORM: begin
          if (|(x_q[46:30] | y_q[46:30])) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 5'd1;
          end else begin
            state_q <= ST_SV_SQX;
          end
        end
        ST_SV_SQX: begin
          if (alu_done) begin
            sq_q    <= alu_rsp.mag;
            state_q <= ST_SV_SQY;
          end
        end
        ST_SV_SQY: begin
          if (alu_done) begin
            sq_q    <= (sq_q + alu_rsp.mag) << 1;
            state_q <= ST_SV_SQRT;
          end
        end
        ST_SV_SQRT: begin
          if (alu_done) begin
            s_q     <= {17'b0, alu_rsp.mag[31:0]} << k_q;
            cand_q  <= 1'b0;
            found_q <= 1'b0;
            state_q <= ST_SV_C;
          end
        end
        ST_SV_C: begin
          if (alu_done) begin
            if (c_skip || (diff_w == 42'sd0)) begin
              if (cand_q) state_q <= ST_SV_PICK;
              else cand_q <= 1'b1;
            end else begin
              c_q     <= alu_rsp.mag[31:0];
              diff_q  <= diff_w[33:0];
              state_q <= ST_SV_CA;
            end
          end
        end
        ST_SV_CA: begin
          if (alu_done) begin
            if (!found_q || (alu_rsp.mag[46:0] < best_mag_q)) begin
              best_q     <= alu_val[47:0];
              best_mag_q <= alu_rsp.mag[46:0];
              bt_q       <= c_q;
              found_q    <= 1'b1;
            end
            if (cand_q) begin
              state_q <= ST_SV_PICK;
            end else begin
              cand_q  <= 1'b1;
              state_q <= ST_SV_C;
            end
          end
        end
        ST_SV_PICK: begin
          if (found_q) begin
            switch_q <= bt_q;
            accel_q  <= best_q;
            state_q  <= ST_FINISH;
          end else begin
            state_q <= ST_FR_Q1;
          end
        end

        // Fresh plan: a = 4d/T^2 as two divides
        ST_FR_Q1: begin
          if (alu_done) begin
            tmp_q   <= alu_val;
            state_q <= ST_FR_A;
          end
        end
        ST_FR_A: begin
          if (alu_done) begin
            accel_q  <= alu_val[47:0];
            switch_q <= dur_q >> 1;
            state_q  <= ST_FINISH;
          end
        end

        // Tick: advance the plan clock and evaluate the profile
        ST_TK_CHK: begin
          if (dur_q == 32'd0) begin
            state_q <= ST_FINISH;
          end else begin
            elapsed_q <= el_sat;
            if (el_sat >= dur_q) begin
              heading_q <= target_q;
              dur_q     <= '0;
              state_q   <= ST_FINISH;
            end else begin
              past_q  <= el_sat > switch_q;
              acc_q   <= '0;
              state_q <= ST_PP_VT;
            end
          end
        end
        ST_PP_VT: begin
          if (alu_done) begin
            acc_q   <= acc_q + alu_val;
            state_q <= ST_PP_AT;
          end
        end
        ST_PP_AT: begin
          if (alu_done) begin
            tmp_q   <= alu_val;
            state_q <= ST_PP_HALF;
          end
        end
        ST_PP_HALF: begin
          if (alu_done) begin
            acc_q <= acc_q + alu_val;
            if (past_q) begin
              v1_q    <= clamp_vel($signed(ext48(vel0_q)) + tmp_q);
              state_q <= ST_PP_V1T;
            end else begin
              state_q <= ST_PP_END;
            end
          end
        end
        ST_PP_V1T: begin
          if (alu_done) begin
            acc_q   <= acc_q + alu_val;
            state_q <= ST_PP_ADT;
          end
        end
        ST_PP_ADT: begin
          if (alu_done) begin
            tmp_q   <= alu_val;
            state_q <= ST_PP_HALF2;
          end
        end
        ST_PP_HALF2: begin
          if (alu_done) begin
            acc_q   <= acc_q - alu_val;
            state_q <= ST_PP_END;
          end
        end
        ST_PP_END: begin
          heading_q <= sat32($signed(ext32(start_q)) + acc_q);
          state_q   <= ST_FINISH;
        end

        // Nudge heading, and the target while a plan runs
        ST_NUDGE: begin
          heading_q <= sat32($signed(ext32(heading_q)) + $signed(ext32(req_q.nudge_delta)));
          if (dur_q != 32'd0) begin
            target_q <= sat32($signed(ext32(target_q)) + $signed(ext32(req_q.nudge_delta)));
          end
          state_q <= ST_FINISH;
        end

        // Hand the result to the output register once it is free
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.heading      <= heading_q;
            out_data_q.plan_running <= dur_q != 32'd0;
            state_q                 <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Unit results only arrive for a request that was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni) alu_done |-> issued_q)
    else $error("arith result without an issued request");

  // While idle with a plan running, the plan clock is short of the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && dur_q != 32'd0) |-> (elapsed_q < dur_q))
    else $error("plan clock reached the end without finishing");

  // The switch point lies inside the plan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && dur_q != 32'd0) |-> (switch_q <= dur_q))
    else $error("switch point beyond plan duration");

  // A new result is loaded only at the end of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside the finish step");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the heading min-accel planner unit.
`timescale 1ns / 100ps

// Holds the predicted heading/plan flag for each accepted request, in order.
class heading_scoreboard;
  hmap_pkg::rsp_t pending_q[$];
  int             errors;
  int             checked;

  // Print one mismatch line and count it.
  task report(string msg);
    errors++;
    $display("ERROR: %s", msg);
  endtask

  // Queue the predicted result for an accepted request.
  function void note_request(hmap_pkg::rsp_t predicted);
    pending_q.push_back(predicted);
  endfunction

  // Compare one accepted result with the oldest prediction.
  task check_result(hmap_pkg::rsp_t got);
    hmap_pkg::rsp_t want;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result heading=%0d running=%0b",
                       got.heading, got.plan_running));
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (got.heading !== want.heading)
      report($sformatf("result %0d heading got %0d want %0d", checked,
                       got.heading, want.heading));
    if (got.plan_running !== want.plan_running)
      report($sformatf("result %0d plan_running got %0b want %0b", checked,
                       got.plan_running, want.plan_running));
  endtask
endclass

module testbench;

  localparam longint VEL_LIM  = 64'sh7FFF_FFFF_FFFF;
  localparam longint TERM_LIM = 64'sh1000_0000_0000_0000;
  localparam longint LIMIT    = 64'd10_000_000;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b1;
  hmap_pkg::req_t in_data_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  hmap_pkg::rsp_t out_data_o;

  heading_scoreboard board = new();
  longint cycles = 0;
  int     n_sets, n_ticks, n_nudges, n_other;
  int     hold_cnt = 0;

  // Predictor state
  longint m_heading, m_start, m_target, m_vel0, m_accel;
  longint m_sw, m_dur, m_elapsed;

  heading_min_accel_planner_unit dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint sat32(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Exact (|a|*b)>>sh with saturation, sign restored.
  function automatic longint mul_shift(longint a, longint unsigned b, int sh,
                                       longint unsigned cap);
    logic [127:0] p;
    longint unsigned r;
    p = ({64'd0, absval(a)} * {64'd0, b}) >> sh;
    r = (p > {64'd0, cap}) ? cap : p[63:0];
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  // Floor((|n|<<sh)/|d|) with saturation; zero divisor gives zero.
  function automatic longint div_shift(longint n, int sh, longint d,
                                       longint unsigned cap);
    logic [127:0] q;
    longint unsigned r;
    if (d == 0) return 0;
    q = ({64'd0, absval(n)} << sh) / {64'd0, absval(d)};
    r = (q > {64'd0, cap}) ? cap : q[63:0];
    return ((n < 0) != (d < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint half_at_sq(longint a, longint unsigned t);
    return mul_shift(mul_shift(a, t, hmap_pkg::TIME_FRAC, TERM_LIM), t,
                     hmap_pkg::TIME_FRAC + 1, TERM_LIM);
  endfunction

  function automatic longint velocity_at(longint unsigned t);
    longint v;
    if (t <= m_sw) v = m_vel0 + mul_shift(m_accel, t, hmap_pkg::TIME_FRAC, TERM_LIM);
    else v = m_vel0 + mul_shift(m_accel, m_sw, hmap_pkg::TIME_FRAC, TERM_LIM)
             - mul_shift(m_accel, t - m_sw, hmap_pkg::TIME_FRAC, TERM_LIM);
    return clamp(v, VEL_LIM);
  endfunction

  function automatic longint offset_at(longint unsigned t);
    longint v1;
    longint unsigned dt;
    if (t <= m_sw)
      return mul_shift(m_vel0, t, hmap_pkg::TIME_FRAC, TERM_LIM) + half_at_sq(m_accel, t);
    v1 = clamp(m_vel0 + mul_shift(m_accel, m_sw, hmap_pkg::TIME_FRAC, TERM_LIM), VEL_LIM);
    dt = t - m_sw;
    return mul_shift(m_vel0, m_sw, hmap_pkg::TIME_FRAC, TERM_LIM)
           + half_at_sq(m_accel, m_sw)
           + mul_shift(v1, dt, hmap_pkg::TIME_FRAC, TERM_LIM) - half_at_sq(m_accel, dt);
  endfunction

  function automatic void plan_from_rest(longint d, longint unsigned dur);
    longint q1;
    q1 = div_shift(4 * d, hmap_pkg::TIME_FRAC, dur, 64'd1 << 61);
    m_sw = dur >> 1;
    m_accel = div_shift(q1, hmap_pkg::TIME_FRAC, dur, VEL_LIM);
  endfunction

  // Closed-form replan carrying velocity; least-|a| valid root or fresh plan.
  function automatic void plan_with_velocity(longint v0, longint d, longint unsigned dur);
    longint e, s, best, num, den, diff, ca;
    longint unsigned ue, ud, mx, x, y, bt, c;
    int k;
    bit found;
    if (v0 == 0) begin
      plan_from_rest(d, dur);
      return;
    end
    e = mul_shift(v0, dur, hmap_pkg::TIME_FRAC, 64'd1 << 46) - d;
    ue = absval(e);
    ud = absval(d);
    mx = ue > ud ? ue : ud;
    k = 0;
    while ((mx >> k) >= (64'd1 << 30)) k++;
    x = ue >> k;
    y = ud >> k;
    s = longint'(int_sqrt(2 * (x * x + y * y)) << k);
    found = 0;
    best = 0;
    bt = 0;
    den = 2 * v0;
    for (int i = 0; i < 2; i++) begin
      num = (i == 0) ? 2 * d - s : 2 * d + s;
      c = absval(div_shift(num, hmap_pkg::TIME_FRAC, den, 64'd1 << 40));
      if (c != 0 && ((num < 0) != (den < 0))) continue;
      if (c > dur) continue;
      diff = longint'(dur) - 2 * longint'(c);
      if (diff == 0) continue;
      ca = div_shift(v0, hmap_pkg::TIME_FRAC, diff, VEL_LIM);
      if (!found || absval(ca) < absval(best)) begin
        best = ca;
        bt = c;
        found = 1;
      end
    end
    if (!found) plan_from_rest(d, dur);
    else begin
      m_sw = bt;
      m_accel = best;
    end
  endfunction

  // Apply one request to the predictor and return the expected result.
  function automatic hmap_pkg::rsp_t apply_request(hmap_pkg::req_t r);
    hmap_pkg::rsp_t res;
    longint v0, tgt, el;
    case (r.req_type)
      hmap_pkg::REQ_SET: begin
        tgt = r.target_heading;
        if (r.move_duration == 0) begin
          m_heading = tgt;
          m_dur = 0;
        end else begin
          v0 = (m_dur != 0) ? velocity_at(m_elapsed) : 0;
          m_start = m_heading;
          m_target = tgt;
          m_vel0 = v0;
          m_elapsed = 0;
          plan_with_velocity(v0, tgt - m_heading, r.move_duration);
          m_dur = r.move_duration;
        end
      end
      hmap_pkg::REQ_TICK: begin
        if (m_dur != 0) begin
          el = m_elapsed + r.tick_delta;
          m_elapsed = el > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : el;
          if (m_elapsed >= m_dur) begin
            m_heading = m_target;
            m_dur = 0;
          end else m_heading = sat32(m_start + offset_at(m_elapsed));
        end
      end
      hmap_pkg::REQ_NUDGE: begin
        m_heading = sat32(m_heading + longint'(r.nudge_delta));
        if (m_dur != 0) m_target = sat32(m_target + longint'(r.nudge_delta));
      end
      default: ;
    endcase
    res.heading = m_heading[31:0];
    res.plan_running = (m_dur != 0);
    return res;
  endfunction

  // Mostly short gaps, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(60);
  endfunction

  // Send one request and wait for its acceptance; valid drops only over a gap.
  task automatic send_request(hmap_pkg::req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(apply_request(r));
    case (r.req_type)
      hmap_pkg::REQ_SET:   n_sets++;
      hmap_pkg::REQ_TICK:  n_ticks++;
      hmap_pkg::REQ_NUDGE: n_nudges++;
      default:             n_other++;
    endcase
  endtask

  function automatic hmap_pkg::req_t make_req(logic [1:0] kind, logic [31:0] tgt,
                                              logic [31:0] dur, logic [31:0] dt,
                                              logic [31:0] nd);
    hmap_pkg::req_t r;
    r.req_type = kind;
    r.target_heading = tgt;
    r.move_duration = dur;
    r.tick_delta = dt;
    r.nudge_delta = nd;
    return r;
  endfunction

  // Durations mostly a fraction of a second to a few seconds.
  function automatic logic [31:0] rand_dur();
    int p;
    p = $urandom_range(99);
    if (p < 5) return 0;
    if (p < 10) return $urandom();
    if (p < 15) return $urandom_range(8);
    return $urandom_range(32'h4_0000, 32'h800);
  endfunction

  function automatic logic [31:0] rand_angle();
    int p;
    p = $urandom_range(99);
    if (p < 15) return $urandom();
    return $signed($urandom_range(32'h0C00_0000)) - 32'sh0600_0000;
  endfunction

  // Output side: random stall with occasional long holds, check accepted results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if (hold_cnt != 0) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= hold_cnt - 1;
      end else if ($urandom_range(199) < 3) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= $urandom_range(80, 20);
      end else begin
        out_stall_i <= ($urandom_range(99) < 30) ? 1'b1 : 1'b0;
      end
    end
  end

  initial begin
    hmap_pkg::req_t r;
    int   waited;
    m_heading = 0; m_start = 0; m_target = 0; m_vel0 = 0; m_accel = 0;
    m_sw = 0; m_dur = 0; m_elapsed = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every kind, snaps, overflows, idle tick, unused code
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'h1_0000, 0));
    send_request(make_req(REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h7FFF_FFFF, 0, 0, 0));
    send_request(make_req(hmap_pkg::REQ_NUDGE, 0, 0, 0, 32'h7FFF_FFFF));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h8000_0000, 0, 0, 0));
    send_request(make_req(hmap_pkg::REQ_NUDGE, 0, 0, 0, 32'h8000_0000));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h0100_0000, 32'h2_0000, 0, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'h4000, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'h1_4000, 0));
    send_request(make_req(hmap_pkg::REQ_SET, 32'hFE00_0000, 32'h1_0000, 0, 0));
    send_request(make_req(hmap_pkg::REQ_NUDGE, 0, 0, 0, 32'h0010_0000));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'h8000, 0));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'hFFFF_FFFF, 0));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h8000_0000, 32'd1, 0, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 0, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'hFFFF_FFFF, 0));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h7FFF_FFFF, 32'h1_0000, 0, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'h8000, 0));
    send_request(make_req(hmap_pkg::REQ_SET, 32'h7FFF_FFFF, 32'h1_0000, 0, 0));
    send_request(make_req(hmap_pkg::REQ_TICK, 0, 0, 32'hFFFF_FFFF, 0));

    // Random: mostly plans followed by ticks, with retargets and nudges mixed in
    for (int i = 0; i < 1730; i++) begin
      int p;
      p = $urandom_range(99);
      if (p < 22)
        r = make_req(hmap_pkg::REQ_SET, rand_angle(), rand_dur(), $urandom(), $urandom());
      else if (p < 75)
        r = make_req(hmap_pkg::REQ_TICK, $urandom(), $urandom(),
                     ($urandom_range(19) == 0) ? $urandom() : $urandom_range(32'h6000),
                     $urandom());
      else if (p < 95)
        r = make_req(hmap_pkg::REQ_NUDGE, $urandom(), $urandom(), $urandom(),
                     ($urandom_range(9) == 0) ? $urandom()
                       : $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      else r = make_req(REQ_SPARE, $urandom(), $urandom(), $urandom(), $urandom());
      send_request(r);
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    while (waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    $display("Covered %0d sets, %0d ticks, %0d nudges, %0d unused codes; %0d results checked.",
             n_sets, n_ticks, n_nudges, n_other, board.checked);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
sv/hmap_pkg.sv
sv/hmap_alu.sv
sv/heading_min_accel_planner_unit.sv
verif/testbench.sv
